[hw/rtl/mdmac_pkg.sv]
// ----------------------------------------------------------------------------
// mdmac_pkg
// Shared widths and register/mode codes for the multiply/divide/MAC unit.
// ----------------------------------------------------------------------------
package mdmac_pkg;

    localparam int DATA_W = 16;            // operand width
    localparam int PROD_W = 2 * DATA_W;    // product width
    localparam int ACC_W  = 40;            // sum register width
    localparam int STEP_W = 4;             // step counter, DATA_W steps

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    // access kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // write register indexes
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_A_LO   = 3'd1;
    localparam logic [2:0] REG_A_HI   = 3'd2;
    localparam logic [2:0] REG_B_LO   = 3'd3;
    localparam logic [2:0] REG_B_HI   = 3'd4;

    // read register indexes
    localparam logic [2:0] RD_SUM0    = 3'd0;
    localparam logic [2:0] RD_SUM1    = 3'd1;
    localparam logic [2:0] RD_SUM2    = 3'd2;
    localparam logic [2:0] RD_SUM3    = 3'd3;
    localparam logic [2:0] RD_SUM4    = 3'd4;
    localparam logic [2:0] RD_OVF     = 3'd5;

    // modes (any mode with bit 1 set is multiply-accumulate)
    localparam logic [1:0] MODE_MUL   = 2'd0;
    localparam logic [1:0] MODE_DIV   = 2'd1;

    localparam logic [7:0] OVF_BYTE   = 8'h80;

    // unit sequencer states
    localparam logic [1:0] U_IDLE     = 2'd0;
    localparam logic [1:0] U_RUN      = 2'd1;
    localparam logic [1:0] U_FIX      = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

endpackage

[hw/rtl/mul_div_mac_register_unit_core.sv]
// ----------------------------------------------------------------------------
// mul_div_mac_register_unit_core
// Multiply / divide / multiply-accumulate unit behind byte-wide registers.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one bus access per item (s_cmd write/read,
//    s_reg_index, s_write_byte). Output channel m_*: one m_read_byte per
//    item, zero for writes.
//  - Every item produces its result in the output register in the cycle after
//    acceptance. A new item is taken whenever the output register is empty
//    or being drained in the same cycle, and no operation is running.
//  - A write to operand B high starts an operation: its result item is
//    returned at once, but the next item waits for the arithmetic.
//    Multiply and MAC run 16 bit-serial shift-add steps in the
//    multiplier, then one sign fix and one write into the sum; divide runs
//    16 restoring steps in the divider, sign fix, write. Divide by
//    zero completes without the divider. Other accesses do not block input.
//  - Reset clears mode, operands, the 40-bit sum and the overflow flag.
//  - If the receiver stalls, the result item holds and input stays blocked.
// ----------------------------------------------------------------------------
module mul_div_mac_register_unit_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_write_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte
);

    logic [1:0]                    mode_reg, mode_next;
    mdmac_pkg::word_t              op_a_reg, op_a_next;
    mdmac_pkg::word_t              op_b_reg, op_b_next;
    logic [mdmac_pkg::ACC_W-1:0]   accum_reg, accum_next;
    logic                          ovf_reg, ovf_next;
    logic                          busy_reg, busy_next;
    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    rd_reg, rd_next;
    logic                          accept;
    logic                          mul_start, div_start;
    logic                          mul_done, div_done;
    logic [mdmac_pkg::PROD_W-1:0]  product;
    mdmac_pkg::word_t              quotient, remainder;
    mdmac_pkg::word_t              b_full;
    logic [mdmac_pkg::ACC_W:0]     mac_sum;
    logic [7:0]                    rd_byte;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // operand B with the byte being written into its high half
    assign b_full  = {s_write_byte, op_b_reg[7:0]};

    assign mul_start = accept && (s_cmd == mdmac_pkg::CMD_WRITE)
                       && (s_reg_index == mdmac_pkg::REG_B_HI)
                       && (mode_reg != mdmac_pkg::MODE_DIV);
    assign div_start = accept && (s_cmd == mdmac_pkg::CMD_WRITE)
                       && (s_reg_index == mdmac_pkg::REG_B_HI)
                       && (mode_reg == mdmac_pkg::MODE_DIV)
                       && (b_full != '0);

    mdmac_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (op_a_reg),
        .op_b    (b_full),
        .done    (mul_done),
        .product (product)
    );

    mdmac_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (op_a_reg),
        .divisor   (b_full),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // exact accumulate; bit 40 set means below zero or past the top
    assign mac_sum = {1'b0, accum_reg}
                     + {{(mdmac_pkg::ACC_W + 1 - mdmac_pkg::PROD_W)
                         {product[mdmac_pkg::PROD_W-1]}}, product};

    // read data select
    always_comb begin
        unique case (s_reg_index)
            mdmac_pkg::RD_SUM0: rd_byte = accum_reg[7:0];
            mdmac_pkg::RD_SUM1: rd_byte = accum_reg[15:8];
            mdmac_pkg::RD_SUM2: rd_byte = accum_reg[23:16];
            mdmac_pkg::RD_SUM3: rd_byte = accum_reg[31:24];
            mdmac_pkg::RD_SUM4: rd_byte = accum_reg[39:32];
            mdmac_pkg::RD_OVF:  rd_byte = ovf_reg ? mdmac_pkg::OVF_BYTE : 8'h00;
            default:            rd_byte = 8'h00;
        endcase
    end

    // register writes, operation start and completion
    always_comb begin
        mode_next    = mode_reg;
        op_a_next    = op_a_reg;
        op_b_next    = op_b_reg;
        accum_next   = accum_reg;
        ovf_next     = ovf_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        rd_next      = rd_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next = 1'b1;
            rd_next      = (s_cmd == mdmac_pkg::CMD_READ) ? rd_byte : 8'h00;
            if (s_cmd == mdmac_pkg::CMD_WRITE) begin
                unique case (s_reg_index)
                    mdmac_pkg::REG_CTRL: begin
                        if (s_write_byte[1]) begin
                            accum_next = '0;
                        end
                        mode_next = s_write_byte[1:0];
                    end
                    mdmac_pkg::REG_A_LO: op_a_next[7:0]  = s_write_byte;
                    mdmac_pkg::REG_A_HI: op_a_next[15:8] = s_write_byte;
                    mdmac_pkg::REG_B_LO: op_b_next[7:0]  = s_write_byte;
                    mdmac_pkg::REG_B_HI: begin
                        // units latch the operands at start
                        op_b_next = '0;
                        if (mode_reg == mdmac_pkg::MODE_DIV) begin
                            op_a_next = '0;
                            if (b_full == '0) begin
                                accum_next = '0;
                            end else begin
                                busy_next = 1'b1;
                            end
                        end else begin
                            busy_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // completion of a running operation
        if (mul_done) begin
            busy_next = 1'b0;
            if (mode_reg == mdmac_pkg::MODE_MUL) begin
                accum_next = {{(mdmac_pkg::ACC_W - mdmac_pkg::PROD_W)
                               {product[mdmac_pkg::PROD_W-1]}}, product};
            end else begin
                accum_next = mac_sum[mdmac_pkg::ACC_W-1:0];
                ovf_next   = mac_sum[mdmac_pkg::ACC_W];
            end
        end
        if (div_done) begin
            busy_next  = 1'b0;
            accum_next = {8'h00, remainder, quotient};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= mdmac_pkg::MODE_MUL;
            op_a_reg    <= '0;
            op_b_reg    <= '0;
            accum_reg   <= '0;
            ovf_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            op_a_reg    <= op_a_next;
            op_b_reg    <= op_b_next;
            accum_reg   <= accum_next;
            ovf_reg     <= ovf_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        rd_reg <= rd_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = rd_reg;

endmodule

[hw/rtl/mdmac_mul.sv]
// ----------------------------------------------------------------------------
// mdmac_mul
// Bit-serial signed 16x16 multiplier: one shift-add step per cycle on the
// magnitudes, then a sign fix step. Result valid with done, high for a single cycle.
// ----------------------------------------------------------------------------
module mdmac_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  mdmac_pkg::word_t           op_a,
    input  mdmac_pkg::word_t           op_b,
    output logic                       done,
    output logic [mdmac_pkg::PROD_W-1:0] product
);

    logic [1:0]                         state_reg, state_next;
    logic [mdmac_pkg::STEP_W-1:0]       cnt_reg, cnt_next;
    mdmac_pkg::word_t                   mcand_reg, mcand_next;
    mdmac_pkg::word_t                   hi_reg, hi_next;
    mdmac_pkg::word_t                   lo_reg, lo_next;
    logic                               neg_reg, neg_next;
    logic                               done_reg, done_next;
    logic [mdmac_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [mdmac_pkg::DATA_W:0]         step_sum;
    logic [mdmac_pkg::PROD_W-1:0]       mag;

    // partial sum for the current multiplier bit
    assign step_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mag      = {hi_reg, lo_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            mdmac_pkg::U_IDLE: begin
                if (start) begin
                    mcand_next = op_a[mdmac_pkg::DATA_W-1] ? -op_a : op_a;
                    lo_next    = op_b[mdmac_pkg::DATA_W-1] ? -op_b : op_b;
                    hi_next    = '0;
                    neg_next   = op_a[mdmac_pkg::DATA_W-1] ^ op_b[mdmac_pkg::DATA_W-1];
                    cnt_next   = '0;
                    state_next = mdmac_pkg::U_RUN;
                end
            end
            mdmac_pkg::U_RUN: begin
                // shift {carry, hi, lo} right by one
                hi_next  = step_sum[mdmac_pkg::DATA_W:1];
                lo_next  = {step_sum[0], lo_reg[mdmac_pkg::DATA_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mdmac_pkg::LAST_STEP) begin
                    state_next = mdmac_pkg::U_FIX;
                end
            end
            mdmac_pkg::U_FIX: begin
                prod_next  = neg_reg ? -mag : mag;
                done_next  = 1'b1;
                state_next = mdmac_pkg::U_IDLE;
            end
            default: begin
                state_next = mdmac_pkg::U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdmac_pkg::U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

[hw/rtl/mdmac_div.sv]
// ----------------------------------------------------------------------------
// mdmac_div
// Bit-serial restoring divider: signed dividend by unsigned nonzero divisor,
// one quotient bit per cycle, then a sign fix toward zero.
// ----------------------------------------------------------------------------
module mdmac_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  mdmac_pkg::word_t  dividend,
    input  mdmac_pkg::word_t  divisor,
    output logic              done,
    output mdmac_pkg::word_t  quotient,
    output mdmac_pkg::word_t  remainder
);

    logic [1:0]                   state_reg, state_next;
    logic [mdmac_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    mdmac_pkg::word_t             den_reg, den_next;
    mdmac_pkg::word_t             quo_reg, quo_next;
    mdmac_pkg::word_t             rem_reg, rem_next;
    logic                         neg_reg, neg_next;
    logic                         done_reg, done_next;
    mdmac_pkg::word_t             q_out_reg, q_out_next;
    mdmac_pkg::word_t             r_out_reg, r_out_next;
    logic [mdmac_pkg::DATA_W:0]   trial;
    logic [mdmac_pkg::DATA_W:0]   diff;
    logic                         fits;

    // trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[mdmac_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        q_out_next = q_out_reg;
        r_out_next = r_out_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            mdmac_pkg::U_IDLE: begin
                if (start) begin
                    quo_next   = dividend[mdmac_pkg::DATA_W-1] ? -dividend : dividend;
                    neg_next   = dividend[mdmac_pkg::DATA_W-1];
                    den_next   = divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = mdmac_pkg::U_RUN;
                end
            end
            mdmac_pkg::U_RUN: begin
                rem_next = fits ? diff[mdmac_pkg::DATA_W-1:0]
                                : trial[mdmac_pkg::DATA_W-1:0];
                quo_next = {quo_reg[mdmac_pkg::DATA_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mdmac_pkg::LAST_STEP) begin
                    state_next = mdmac_pkg::U_FIX;
                end
            end
            mdmac_pkg::U_FIX: begin
                // both results take the dividend's sign
                q_out_next = neg_reg ? -quo_reg : quo_reg;
                r_out_next = neg_reg ? -rem_reg : rem_reg;
                done_next  = 1'b1;
                state_next = mdmac_pkg::U_IDLE;
            end
            default: begin
                state_next = mdmac_pkg::U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdmac_pkg::U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        q_out_reg <= q_out_next;
        r_out_reg <= r_out_next;
    end

    assign done      = done_reg;
    assign quotient  = q_out_reg;
    assign remainder = r_out_reg;

endmodule
